// ----- src/square_pattern_symmetry_match_unit_macros.svh -----
// Assertion macros for the square pattern symmetry match unit.
`ifndef SQUARE_PATTERN_SYMMETRY_MATCH_UNIT_MACROS_SVH
`define SQUARE_PATTERN_SYMMETRY_MATCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define SPSM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset
`define SPSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPSM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define SPSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- src/spsm_pkg.sv -----
// Shared types, constants and functions of the square pattern symmetry match unit.
package spsm_pkg;

  localparam int MAX_SIZE_DEF = 16;
  localparam int GRID_RESET   = 16;
  localparam int NUM_XFORM    = 8;
  localparam int CLS_W        = 3;

  // Operation codes (carried on tuser)
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  // Transform flag positions
  localparam int XF_ROT90      = 0;
  localparam int XF_ROT180     = 1;
  localparam int XF_ROT270     = 2;
  localparam int XF_MIRROR     = 3;
  localparam int XF_MIR_ROT90  = 4;
  localparam int XF_MIR_ROT180 = 5;
  localparam int XF_MIR_ROT270 = 6;
  localparam int XF_IDENT      = 7;

  // Result classes
  localparam logic [CLS_W-1:0] CLS_ROT90   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_ROT180  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_ROT270  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_MIRROR  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_MIR_ROT = 3'd4;
  localparam logic [CLS_W-1:0] CLS_IDENT   = 3'd5;
  localparam logic [CLS_W-1:0] CLS_NONE    = 3'd6;

  typedef logic [NUM_XFORM-1:0] xform_flags_t;
  typedef logic [7:0]           cell_t;

  // Item control carried from the read stage to the compare stage
  typedef struct packed {
    logic  target;
    logic  in_grid;
    logic  last;
    cell_t value;
  } stage_ctl_t;

  // First matching class in priority order
  function automatic logic [CLS_W-1:0] pick_class(input xform_flags_t f);
    logic [CLS_W-1:0] c;
    if (f[XF_ROT90]) c = CLS_ROT90;
    else if (f[XF_ROT180]) c = CLS_ROT180;
    else if (f[XF_ROT270]) c = CLS_ROT270;
    else if (f[XF_MIRROR]) c = CLS_MIRROR;
    else if (f[XF_MIR_ROT90] | f[XF_MIR_ROT180] | f[XF_MIR_ROT270]) c = CLS_MIR_ROT;
    else if (f[XF_IDENT]) c = CLS_IDENT;
    else c = CLS_NONE;
    return c;
  endfunction

endpackage

// ----- src/spsm_addr_gen.sv -----
// Grid bounds check and the eight transformed source addresses of one cell.
module spsm_addr_gen #(
  parameter int MAX_SIZE = spsm_pkg::MAX_SIZE_DEF,
  parameter int NW       = 5,
  parameter int AW       = 8
) (
  input  logic [NW-1:0]                            n,
  input  logic [3:0]                               row,
  input  logic [3:0]                               col,
  output logic                                     in_grid,
  output logic [spsm_pkg::NUM_XFORM-1:0][AW-1:0]   addr
);
  import spsm_pkg::*;

  localparam int CW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CMPW = (NW > 4) ? NW : 4;

  logic [CMPW-1:0] r_w, c_w, n_w, m_w, mr_w, mc_w;
  logic [CW-1:0]   r, c, mr, mc;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] rr, input logic [CW-1:0] cc);
    logic [AW-1:0] a;
    a = AW'(rr) * AW'(MAX_SIZE) + AW'(cc);
    return a;
  endfunction

  // Bounds and mirrored coordinates
  always_comb begin
    r_w     = CMPW'(row);
    c_w     = CMPW'(col);
    n_w     = CMPW'(n);
    m_w     = n_w - CMPW'(1);
    mr_w    = m_w - r_w;
    mc_w    = m_w - c_w;
    in_grid = (r_w < n_w) && (c_w < n_w);
    r       = r_w[CW-1:0];
    c       = c_w[CW-1:0];
    mr      = mr_w[CW-1:0];
    mc      = mc_w[CW-1:0];
  end

  // Source position that each transform maps onto this target cell
  always_comb begin
    addr[XF_ROT90]      = cell_addr(mc, r);
    addr[XF_ROT180]     = cell_addr(mr, mc);
    addr[XF_ROT270]     = cell_addr(c, mr);
    addr[XF_MIRROR]     = cell_addr(r, mc);
    addr[XF_MIR_ROT90]  = cell_addr(mc, mr);
    addr[XF_MIR_ROT180] = cell_addr(mr, c);
    addr[XF_MIR_ROT270] = cell_addr(c, r);
    addr[XF_IDENT]      = cell_addr(r, c);
  end

endmodule

// ----- src/spsm_src_bank.sv -----
// One copy of the source cell store: one write port, one registered read port.
module spsm_src_bank #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  spsm_pkg::cell_t      wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output spsm_pkg::cell_t      rdata
);
  import spsm_pkg::*;

  cell_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/spsm_flag_unit.sv -----
// Per-transform match flags and result class selection.
module spsm_flag_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  spsm_pkg::stage_ctl_t                    ctl,
  input  spsm_pkg::cell_t [spsm_pkg::NUM_XFORM-1:0] rd_data,
  output spsm_pkg::xform_flags_t                  flags,
  output logic [spsm_pkg::CLS_W-1:0]              cls
);
  import spsm_pkg::*;

  xform_flags_t hit;
  xform_flags_t flags_next;

  // Compare target value against each transformed source cell
  always_comb begin
    for (int i = 0; i < NUM_XFORM; i++) begin
      hit[i] = (rd_data[i] == ctl.value);
    end
    flags_next = (ctl.target && ctl.in_grid) ? (flags & hit) : flags;
    cls        = pick_class(flags_next);
  end

  // Flags restart at all ones after each result
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '1;
    end else if (en && ctl.target) begin
      flags <= ctl.last ? '1 : flags_next;
    end
  end

endmodule

// ----- src/square_pattern_symmetry_match_unit.sv -----
// Cells pass the input, read stage and output registers; a pending result stalls all.
// Throughput: one cell per cycle unless stalled; eight copies give the eight reads.
// The store has one write and one registered read port per copy.
// Reset clears all valids and match flags; grid_size goes to 16, or MAX_SIZE if less.
// The source store is not cleared: source cells must be written before they are compared.
`include "square_pattern_symmetry_match_unit_macros.svh"

module square_pattern_symmetry_match_unit #(
  parameter int MAX_SIZE = spsm_pkg::MAX_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: grid_size
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  // input cells
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // row[3:0], col[7:4], cell_value[15:8]
  input  logic        s_tuser,   // operation[0]
  input  logic        s_tlast,
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // match_class[2:0], zero[7:3]
);
  import spsm_pkg::*;

  localparam int NW       = $clog2(MAX_SIZE + 1);
  localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CFW      = (NW > 5) ? NW : 5;
  localparam int GRID_RST = (GRID_RESET > MAX_SIZE) ? MAX_SIZE : GRID_RESET;

  logic [NW-1:0]  grid_n;
  logic [CFW-1:0] cfg_ext;
  logic           advance;

  // Input register
  logic       v1;
  logic       op1;
  logic [3:0] row1;
  logic [3:0] col1;
  cell_t      val1;
  logic       last1;

  // Read stage register
  logic       v2;
  stage_ctl_t ctl2;

  logic                           in_grid1;
  logic [NUM_XFORM-1:0][AW-1:0]   addr1;
  cell_t [NUM_XFORM-1:0]          rd_data;
  xform_flags_t                   flags;
  logic [CLS_W-1:0]               cls;
  logic                           src_we;
  logic [CLS_W-1:0]               match_class;

  // Grid size register, clamped to 1..MAX_SIZE on write
  assign cfg_ready = 1'b1;
  assign cfg_ext   = CFW'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_n <= NW'(GRID_RST);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_ext == '0) begin
        grid_n <= NW'(1);
      end else if (cfg_ext > CFW'(MAX_SIZE)) begin
        grid_n <= NW'(MAX_SIZE);
      end else begin
        grid_n <= NW'(cfg_ext);
      end
    end
  end

  // Whole pipeline moves unless a result waits at the output
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op1   <= s_tuser;
      row1  <= s_tdata[3:0];
      col1  <= s_tdata[7:4];
      val1  <= s_tdata[15:8];
      last1 <= s_tlast;
    end
  end

  spsm_addr_gen #(
    .MAX_SIZE (MAX_SIZE),
    .NW       (NW),
    .AW       (AW)
  ) u_addr_gen (
    .n       (grid_n),
    .row     (row1),
    .col     (col1),
    .in_grid (in_grid1),
    .addr    (addr1)
  );

  // Source writes land before the next transaction reads
  assign src_we = advance && v1 && (op1 == OP_WRITE) && in_grid1;

  for (genvar g = 0; g < NUM_XFORM; g++) begin : g_bank
    spsm_src_bank #(
      .DEPTH (DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk   (clk),
      .we    (src_we),
      .waddr (addr1[XF_IDENT]),
      .wdata (val1),
      .re    (advance),
      .raddr (addr1[g]),
      .rdata (rd_data[g])
    );
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl2.target  <= (op1 == OP_TARGET);
      ctl2.in_grid <= in_grid1;
      ctl2.last    <= last1;
      ctl2.value   <= val1;
    end
  end

  spsm_flag_unit u_flag_unit (
    .clk     (clk),
    .rst     (rst),
    .en      (advance && v2),
    .ctl     (ctl2),
    .rd_data (rd_data),
    .flags   (flags),
    .cls     (cls)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= v2 && ctl2.target && ctl2.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      match_class <= cls;
    end
  end

  assign m_tdata = {{(8 - CLS_W){1'b0}}, match_class};

  `SPSM_ASSERT_NEXT(a_result_follows_last, clk, rst, advance && v2 && ctl2.target && ctl2.last, m_tvalid, "last target cell gave no result")
  `SPSM_ASSERT_NEXT(a_flags_restart, clk, rst, advance && v2 && ctl2.target && ctl2.last, flags == '1, "match flags not restored after result")
  `SPSM_ASSERT_NOW(a_class_range, clk, rst, m_tvalid, match_class <= CLS_NONE, "result class out of range")
  `SPSM_ASSERT_NOW(a_grid_range, clk, rst, 1'b1, (grid_n != '0) && (grid_n <= NW'(MAX_SIZE)), "effective grid size out of range")

endmodule
